// File: hw/rtl/gle_pkg.sv
// Shared types, constants and helpers for the GPIB listener receive engine.
// Used by gle_term_detect, gle_step and gpib_listener_receive_engine; no dependencies.
`timescale 1ns / 1ps

package gle_pkg;

	// Width of the per-edge wait timer; it saturates at its all-ones value.
	localparam int TimerBits = 16;
	localparam int TimeoutW  = 16;
	localparam int CmpW      = (TimerBits > TimeoutW) ? TimerBits : TimeoutW;
	localparam logic [TimerBits-1:0] TimerMax = '1;

	// Bus characters used by the terminator sequences.
	localparam logic [7:0] ChEtx = 8'h03;
	localparam logic [7:0] ChCr  = 8'h0D;
	localparam logic [7:0] ChLf  = 8'h0A;

	// Configuration register indexes.
	localparam logic [2:0] RegTimeout    = 3'd0;
	localparam logic [2:0] RegEoiOnly    = 3'd1;
	localparam logic [2:0] RegTermMode   = 3'd2;
	localparam logic [2:0] RegStopCharEn = 3'd3;
	localparam logic [2:0] RegStopChar   = 3'd4;
	localparam logic [2:0] RegEotEn      = 3'd5;

	// Terminator modes.
	localparam logic [2:0] TmCrLf    = 3'd0;
	localparam logic [2:0] TmCr      = 3'd1;
	localparam logic [2:0] TmLf      = 3'd2;
	localparam logic [2:0] TmNone    = 3'd3;
	localparam logic [2:0] TmLfCr    = 3'd4;
	localparam logic [2:0] TmEtx     = 3'd5;
	localparam logic [2:0] TmCrLfEtx = 3'd6;
	localparam logic [2:0] TmEoi     = 3'd7;

	// End status codes.
	localparam logic [2:0] StRunning = 3'd0;
	localparam logic [2:0] StEoi     = 3'd1;
	localparam logic [2:0] StTerm    = 3'd2;
	localparam logic [2:0] StDavLow  = 3'd3;
	localparam logic [2:0] StDavHigh = 3'd4;
	localparam logic [2:0] StAtn     = 3'd5;
	localparam logic [2:0] StBreak   = 3'd6;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_BREAK  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_WAIT_LOW  = 2'd1,
		PH_WAIT_HIGH = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TimeoutW-1:0] timeout_ticks;
		logic                eoi_only;
		logic [2:0]          term_mode;
		logic                stop_char_en;
		logic [7:0]          stop_char;
		logic                eot_en;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic       dav_low;
		logic       eoi_low;
		logic       atn_low;
		logic [7:0] bus_byte;
	} item_t;

	typedef struct packed {
		phase_t               phase;
		logic [TimerBits-1:0] wait_timer;
		logic [7:0]           held_byte;
		logic                 held_eoi;
		logic [7:0]           prev_byte;
		logic [7:0]           prev_prev_byte;
	} state_t;

	typedef struct packed {
		logic       listening;
		logic       nrfd_release;
		logic       ndac_release;
		logic       byte_valid;
		logic [7:0] rx_byte;
		logic       last;
		logic [2:0] end_status;
		logic       append_eot;
	} result_t;

	// Result that only reports the handshake lines for a given phase.
	function automatic result_t lines_for(phase_t ph);
		result_t r;
		r = '0;
		unique case (ph)
			PH_WAIT_LOW: begin
				r.listening    = 1'b1;
				r.nrfd_release = 1'b1;
			end
			PH_WAIT_HIGH: begin
				r.listening    = 1'b1;
				r.ndac_release = 1'b1;
			end
			default: begin
				r.nrfd_release = 1'b1;
				r.ndac_release = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Timeout limit, clipped to what the timer can count.
	function automatic logic [TimerBits-1:0] timer_limit(logic [TimeoutW-1:0] ticks);
		logic [CmpW-1:0] t;
		t = CmpW'(ticks);
		if (t > CmpW'(TimerMax))
			return TimerMax;
		return TimerBits'(t);
	endfunction

endpackage

// File: hw/rtl/gpib_listener_receive_engine.sv
// Top level of the GPIB listener receive engine: input register, state and result register.
// Depends on gle_pkg and instantiates gle_step.
`timescale 1ns / 1ps

// Usage
// The host sends one transfer per bus tick on the s_ group: s_tuser carries the command
// (tick with line sample, start, break) and s_tdata the sampled DAV, EOI, ATN lines and DIO.
// Every input transfer produces exactly one result transfer on the m_ group, carrying the
// NRFD/NDAC drive, the listening flag, any accepted byte, the end status and the EOT request;
// m_tlast marks the result that ends a receive.
// The item waits in the input register and passes through the handshake logic into the
// result register. Throughput is one item per cycle while m_tready is high; the input
// register and the result register are decoupled, so a new item is taken while a
// finished result still waits on m_tready. When m_tready is low the result holds, the
// input register fills, and s_tready drops only once both are occupied.
// Configuration is written through wr_en/wr_index/wr_data, one register per cycle; the
// user must write it only while the engine is idle, which the block does not enforce.
// Indexes beyond the register list are ignored.
// Reset empties both registers, returns the handshake to idle with all state cleared and
// loads the configuration defaults (1200-tick timeout, end on EOI).

module gpib_listener_receive_engine (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // dav_low, eoi_low, atn_low, bus_byte[7:0], zero padding
	input  logic [1:0]  s_tuser,  // op
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // listening, nrfd_release, ndac_release, byte_valid,
	                              // rx_byte[7:0], end_status[2:0], append_eot
	output logic        m_tlast   // last
);

	gle_pkg::cfg_t    cfg_q;
	gle_pkg::item_t   item_s1;
	logic             valid_s1;
	gle_pkg::state_t  state_q;
	gle_pkg::state_t  state_next;
	gle_pkg::result_t res_next;
	gle_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;

	// The input register moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd1200;
			cfg_q.eoi_only      <= 1'b1;
			cfg_q.term_mode     <= gle_pkg::TmCrLf;
			cfg_q.stop_char_en  <= 1'b0;
			cfg_q.stop_char     <= gle_pkg::ChLf;
			cfg_q.eot_en        <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				gle_pkg::RegTimeout:    cfg_q.timeout_ticks <= wr_data;
				gle_pkg::RegEoiOnly:    cfg_q.eoi_only      <= wr_data[0];
				gle_pkg::RegTermMode:   cfg_q.term_mode     <= wr_data[2:0];
				gle_pkg::RegStopCharEn: cfg_q.stop_char_en  <= wr_data[0];
				gle_pkg::RegStopChar:   cfg_q.stop_char     <= wr_data[7:0];
				gle_pkg::RegEotEn:      cfg_q.eot_en        <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op       <= gle_pkg::op_t'(s_tuser);
			item_s1.dav_low  <= s_tdata[0];
			item_s1.eoi_low  <= s_tdata[1];
			item_s1.atn_low  <= s_tdata[2];
			item_s1.bus_byte <= s_tdata[10:3];
		end
	end

	gle_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (res_next)
	);

	// Handshake state advances once per item handed to the result register.
	// The idle phase is encoded as zero, so clearing the whole state leaves it idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {res_q.append_eot, res_q.end_status, res_q.rx_byte, res_q.byte_valid,
			res_q.ndac_release, res_q.nrfd_release, res_q.listening};

	// An ending result always leaves the handshake idle.
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
			advance && res_next.last |=> state_q.phase == gle_pkg::PH_IDLE)
		else $error("receive ended but handshake not idle");

	// A delivered byte always comes with NRFD released.
	a_byte_nrfd: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_q && res_q.byte_valid |-> res_q.nrfd_release)
		else $error("byte delivered while NRFD held");

	// An idle handshake keeps its wait timer cleared.
	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
			state_q.phase == gle_pkg::PH_IDLE |-> state_q.wait_timer == '0)
		else $error("wait timer running while idle");

	// Every item leaving the input register appears as a result.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
			advance |=> out_valid_q)
		else $error("result lost");

endmodule

// File: hw/rtl/gle_term_detect.sv
// Terminator matcher: compares the last three received bytes against the configured sequence.
// Depends on gle_pkg for the configuration type and character constants.
`timescale 1ns / 1ps

module gle_term_detect (
	input  gle_pkg::cfg_t cfg,
	input  logic [7:0]    b0,
	input  logic [7:0]    b1,
	input  logic [7:0]    b2,
	output logic          hit
);

	// The stop character overrides the sequence selection.
	always_comb begin
		if (cfg.stop_char_en) begin
			hit = (b0 == cfg.stop_char);
		end else begin
			unique case (cfg.term_mode)
				gle_pkg::TmCr:      hit = (b0 == gle_pkg::ChCr);
				gle_pkg::TmLf:      hit = (b0 == gle_pkg::ChLf);
				gle_pkg::TmNone:    hit = 1'b0;
				gle_pkg::TmLfCr:    hit = (b0 == gle_pkg::ChCr) && (b1 == gle_pkg::ChLf);
				gle_pkg::TmEtx:     hit = (b0 == gle_pkg::ChEtx);
				gle_pkg::TmCrLfEtx: hit = (b0 == gle_pkg::ChEtx) && (b1 == gle_pkg::ChLf)
						&& (b2 == gle_pkg::ChCr);
				default:            hit = (b0 == gle_pkg::ChLf) && (b1 == gle_pkg::ChCr);
			endcase
		end
	end

endmodule

// File: hw/rtl/gle_step.sv
// Next-state and result logic of the acceptor handshake for one line sample or command.
// Depends on gle_pkg and instantiates gle_term_detect.
`timescale 1ns / 1ps

module gle_step (
	input  gle_pkg::cfg_t    cfg,
	input  gle_pkg::state_t  st,
	input  gle_pkg::item_t   item,
	output gle_pkg::state_t  nxt,
	output gle_pkg::result_t res
);

	logic                          term_hit;
	logic                          eoi_mode;
	logic [gle_pkg::TimerBits-1:0] limit;
	logic [gle_pkg::TimerBits-1:0] timer_inc;
	logic                          expired;

	gle_term_detect u_term (
		.cfg (cfg),
		.b0  (st.held_byte),
		.b1  (st.prev_byte),
		.b2  (st.prev_prev_byte),
		.hit (term_hit)
	);

	// Saturating wait timer and its expiry against the configured limit.
	always_comb begin
		eoi_mode  = cfg.eoi_only || (cfg.term_mode == gle_pkg::TmEoi);
		limit     = gle_pkg::timer_limit(cfg.timeout_ticks);
		timer_inc = (st.wait_timer != gle_pkg::TimerMax) ?
				st.wait_timer + 1'b1 : st.wait_timer;
		expired   = (timer_inc >= limit);
	end

	// Handshake sequencing; an ending result returns the engine to idle.
	always_comb begin
		nxt = st;
		res = gle_pkg::lines_for(st.phase);
		unique case (item.op)
			gle_pkg::OP_UNUSED: begin
				res = gle_pkg::lines_for(st.phase);
			end
			gle_pkg::OP_START: begin
				nxt       = '0;
				nxt.phase = gle_pkg::PH_WAIT_LOW;
				res       = gle_pkg::lines_for(gle_pkg::PH_WAIT_LOW);
			end
			default: begin
				if (st.phase == gle_pkg::PH_IDLE) begin
					res = gle_pkg::lines_for(gle_pkg::PH_IDLE);
				end else begin
					// Ending result template: lines released, receive over.
					res              = gle_pkg::lines_for(gle_pkg::PH_IDLE);
					res.last         = 1'b1;
					nxt.phase        = gle_pkg::PH_IDLE;
					nxt.wait_timer   = '0;
					if (item.op == gle_pkg::OP_BREAK) begin
						res.end_status = gle_pkg::StBreak;
					end else if (item.atn_low) begin
						res.end_status = gle_pkg::StAtn;
					end else if (st.phase == gle_pkg::PH_WAIT_LOW) begin
						if (item.dav_low) begin
							nxt.held_byte  = item.bus_byte;
							nxt.held_eoi   = eoi_mode && item.eoi_low;
							nxt.phase      = gle_pkg::PH_WAIT_HIGH;
							nxt.wait_timer = '0;
							res = gle_pkg::lines_for(gle_pkg::PH_WAIT_HIGH);
						end else if (expired) begin
							res.end_status = gle_pkg::StDavLow;
						end else begin
							nxt.phase      = gle_pkg::PH_WAIT_LOW;
							nxt.wait_timer = timer_inc;
							res = gle_pkg::lines_for(gle_pkg::PH_WAIT_LOW);
						end
					end else if (item.dav_low) begin
						// Talker still holds DAV: wait or time out with the held byte.
						if (expired) begin
							res.byte_valid = 1'b1;
							res.rx_byte    = st.held_byte;
							res.end_status = gle_pkg::StDavHigh;
							res.append_eot = st.held_eoi & cfg.eot_en;
						end else begin
							nxt.phase      = gle_pkg::PH_WAIT_HIGH;
							nxt.wait_timer = timer_inc;
							res = gle_pkg::lines_for(gle_pkg::PH_WAIT_HIGH);
						end
					end else if (eoi_mode && st.held_eoi) begin
						res.byte_valid = 1'b1;
						res.rx_byte    = st.held_byte;
						res.end_status = gle_pkg::StEoi;
						res.append_eot = cfg.eot_en;
					end else if (!eoi_mode && term_hit) begin
						res.byte_valid = 1'b1;
						res.rx_byte    = st.held_byte;
						res.end_status = gle_pkg::StTerm;
					end else begin
						// Byte accepted, receive continues.
						nxt.prev_prev_byte = st.prev_byte;
						nxt.prev_byte      = st.held_byte;
						nxt.phase          = gle_pkg::PH_WAIT_LOW;
						nxt.wait_timer     = '0;
						res                = gle_pkg::lines_for(gle_pkg::PH_WAIT_LOW);
						res.byte_valid     = 1'b1;
						res.rx_byte        = st.held_byte;
					end
				end
			end
		endcase
	end

endmodule

// File: sim/gpib_listener_receive_engine_tb.sv
// Self-checking testbench for the GPIB listener receive engine: drives line samples and
// commands, predicts each result transfer with its own acceptor model and checks every field.
// Depends on gle_pkg and gpib_listener_receive_engine.
`timescale 1ns / 1ps

module gpib_listener_receive_engine_tb;

	localparam int HoldCycles = 60;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;

	gpib_listener_receive_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Settings as the engine holds them.
	logic [15:0] cfg_timeout   = 16'd1200;
	logic        cfg_eoi_only  = 1'b1;
	logic [2:0]  cfg_term_mode = gle_pkg::TmCrLf;
	logic        cfg_stop_en   = 1'b0;
	logic [7:0]  cfg_stop_char = 8'h0A;
	logic        cfg_eot_en    = 1'b0;

	// Acceptor state as predicted.
	gle_pkg::phase_t               rx_phase   = gle_pkg::PH_IDLE;
	logic [gle_pkg::TimerBits-1:0] wait_count = '0;
	logic [7:0]                    held_byte  = '0;
	logic                          held_eoi   = 1'b0;
	logic [7:0]                    prev_byte  = '0;
	logic [7:0]                    prev2_byte = '0;

	gle_pkg::result_t expected_results[$];
	int               fault_count = 0;
	int               sent_items  = 0;
	bit               no_idle     = 1'b0;
	bit               hold_req    = 1'b0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Handshake lines that each phase drives while no receive ends.
	function automatic gle_pkg::result_t handshake_lines(gle_pkg::phase_t ph);
		gle_pkg::result_t r;
		r = '0;
		case (ph)
			gle_pkg::PH_WAIT_LOW: begin
				r.listening    = 1'b1;
				r.nrfd_release = 1'b1;
			end
			gle_pkg::PH_WAIT_HIGH: begin
				r.listening    = 1'b1;
				r.ndac_release = 1'b1;
			end
			default: begin
				r.nrfd_release = 1'b1;
				r.ndac_release = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Closes the receive and builds the ending result.
	function automatic gle_pkg::result_t end_receive(logic valid, logic [7:0] b,
			logic [2:0] status, logic eot);
		gle_pkg::result_t r;
		rx_phase       = gle_pkg::PH_IDLE;
		wait_count     = '0;
		r              = '0;
		r.nrfd_release = 1'b1;
		r.ndac_release = 1'b1;
		r.byte_valid   = valid;
		r.rx_byte      = valid ? b : 8'h00;
		r.last         = 1'b1;
		r.end_status   = status;
		r.append_eot   = eot;
		return r;
	endfunction

	// One tick of waiting for a DAV edge; true once the wait has run out.
	function automatic logic wait_expired();
		if (wait_count != gle_pkg::TimerMax)
			wait_count = wait_count + 1'b1;
		return wait_count >= cfg_timeout;
	endfunction

	// Terminator match on the newest byte and the two before it.
	function automatic logic terminator_hit();
		if (cfg_stop_en)
			return held_byte == cfg_stop_char;
		case (cfg_term_mode)
			gle_pkg::TmCr:      return held_byte == gle_pkg::ChCr;
			gle_pkg::TmLf:      return held_byte == gle_pkg::ChLf;
			gle_pkg::TmNone:    return 1'b0;
			gle_pkg::TmLfCr:    return held_byte == gle_pkg::ChCr && prev_byte == gle_pkg::ChLf;
			gle_pkg::TmEtx:     return held_byte == gle_pkg::ChEtx;
			gle_pkg::TmCrLfEtx: return held_byte == gle_pkg::ChEtx
					&& prev_byte == gle_pkg::ChLf && prev2_byte == gle_pkg::ChCr;
			default:            return held_byte == gle_pkg::ChLf && prev_byte == gle_pkg::ChCr;
		endcase
	endfunction

	// Advances the predicted acceptor by one accepted item and returns its result.
	function automatic gle_pkg::result_t listener_predict(gle_pkg::item_t it);
		gle_pkg::result_t r;
		logic             eoi_mode;
		eoi_mode = cfg_eoi_only || cfg_term_mode == gle_pkg::TmEoi;
		if (it.op == gle_pkg::OP_UNUSED)
			return handshake_lines(rx_phase);
		if (it.op == gle_pkg::OP_START) begin
			rx_phase   = gle_pkg::PH_WAIT_LOW;
			wait_count = '0;
			held_byte  = '0;
			held_eoi   = 1'b0;
			prev_byte  = '0;
			prev2_byte = '0;
			return handshake_lines(rx_phase);
		end
		if (rx_phase == gle_pkg::PH_IDLE)
			return handshake_lines(rx_phase);
		if (it.op == gle_pkg::OP_BREAK)
			return end_receive(1'b0, 8'h00, gle_pkg::StBreak, 1'b0);
		if (it.atn_low)
			return end_receive(1'b0, 8'h00, gle_pkg::StAtn, 1'b0);
		if (rx_phase == gle_pkg::PH_WAIT_LOW) begin
			if (it.dav_low) begin
				held_byte  = it.bus_byte;
				held_eoi   = eoi_mode && it.eoi_low;
				rx_phase   = gle_pkg::PH_WAIT_HIGH;
				wait_count = '0;
			end else if (wait_expired()) begin
				return end_receive(1'b0, 8'h00, gle_pkg::StDavLow, 1'b0);
			end
			return handshake_lines(rx_phase);
		end
		// Waiting for DAV to be released.
		if (it.dav_low) begin
			if (wait_expired())
				return end_receive(1'b1, held_byte, gle_pkg::StDavHigh,
						held_eoi & cfg_eot_en);
			return handshake_lines(rx_phase);
		end
		if (eoi_mode) begin
			if (held_eoi)
				return end_receive(1'b1, held_byte, gle_pkg::StEoi, cfg_eot_en);
		end else if (terminator_hit()) begin
			return end_receive(1'b1, held_byte, gle_pkg::StTerm, 1'b0);
		end
		prev2_byte   = prev_byte;
		prev_byte    = held_byte;
		rx_phase     = gle_pkg::PH_WAIT_LOW;
		wait_count   = '0;
		r            = handshake_lines(rx_phase);
		r.byte_valid = 1'b1;
		r.rx_byte    = held_byte;
		return r;
	endfunction

	// Offers one item, waits for its transfer and records the expected result.
	// Called and returns at a falling edge; tvalid is left high for the next caller.
	task automatic send_item(gle_pkg::op_t op, logic dav, logic eoi, logic atn,
			logic [7:0] data);
		gle_pkg::item_t it;
		it.op       = op;
		it.dav_low  = dav;
		it.eoi_low  = eoi;
		it.atn_low  = atn;
		it.bus_byte = data;
		while (!no_idle && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, data, atn, eoi, dav};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		sent_items++;
		expected_results.push_back(listener_predict(it));
		@(negedge clk);
	endtask

	// One byte on the bus: DAV high for a while, DAV low, then DAV released.
	task automatic send_byte(logic [7:0] b, logic eoi, int gap, int hold);
		repeat (gap)
			send_item(gle_pkg::OP_TICK, 1'b0, 1'($urandom_range(1)), 1'b0,
				8'($urandom_range(255)));
		repeat (hold)
			send_item(gle_pkg::OP_TICK, 1'b1, eoi, 1'b0, b);
		send_item(gle_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'($urandom_range(255)));
	endtask

	// Stops offering items and waits until every expected result has come.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes one register and records the new value in the predicted settings.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			gle_pkg::RegTimeout:    cfg_timeout   = val;
			gle_pkg::RegEoiOnly:    cfg_eoi_only  = val[0];
			gle_pkg::RegTermMode:   cfg_term_mode = val[2:0];
			gle_pkg::RegStopCharEn: cfg_stop_en   = val[0];
			gle_pkg::RegStopChar:   cfg_stop_char = val[7:0];
			gle_pkg::RegEotEn:      cfg_eot_en    = val[0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Every register gets a fresh value, extremes included.
	task automatic random_settings();
		logic [15:0] tmo;
		logic [7:0]  sc;
		case ($urandom_range(7))
			0: tmo = 16'd0;
			1: tmo = 16'd1;
			2: tmo = 16'd2;
			3: tmo = 16'd3;
			4: tmo = 16'd5;
			5: tmo = 16'hFFFF;
			default: tmo = 16'($urandom_range(1, 20));
		endcase
		case ($urandom_range(4))
			0: sc = 8'h00;
			1: sc = 8'hFF;
			2: sc = gle_pkg::ChCr;
			3: sc = gle_pkg::ChLf;
			default: sc = 8'($urandom_range(255));
		endcase
		write_reg(gle_pkg::RegTimeout, tmo);
		write_reg(gle_pkg::RegEoiOnly, 16'($urandom_range(2) == 0));
		write_reg(gle_pkg::RegTermMode, 16'($urandom_range(7)));
		write_reg(gle_pkg::RegStopCharEn, 16'($urandom_range(3) == 0));
		write_reg(gle_pkg::RegStopChar, {8'h00, sc});
		write_reg(gle_pkg::RegEotEn, 16'($urandom_range(1)));
	endtask

	// Something that interrupts a receive or does nothing.
	task automatic send_disruption();
		case ($urandom_range(4))
			0: send_item(gle_pkg::OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'b1, 8'($urandom_range(255)));
			1: send_item(gle_pkg::OP_BREAK, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 8'($urandom_range(255)));
			2: send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'($urandom_range(255)));
			3: send_item(gle_pkg::OP_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 8'($urandom_range(255)));
			default:
				repeat ($urandom_range(1, 8))
					send_item(gle_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'($urandom_range(255)));
		endcase
	endtask

	// Items with every field at random.
	task automatic send_noise();
		repeat ($urandom_range(1, 3))
			send_item(gle_pkg::op_t'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	// A well-formed receive with random content, often closed by a terminator sequence.
	task automatic send_message();
		logic [7:0] body[$];
		int         n;
		logic       eoi;
		n = $urandom_range(1, 8);
		repeat (n) begin
			case ($urandom_range(9))
				0: body.push_back(gle_pkg::ChCr);
				1: body.push_back(gle_pkg::ChLf);
				2: body.push_back(gle_pkg::ChEtx);
				3: body.push_back(cfg_stop_char);
				default: body.push_back(8'($urandom_range(255)));
			endcase
		end
		case ($urandom_range(3))
			0: begin
				body.push_back(gle_pkg::ChCr);
				body.push_back(gle_pkg::ChLf);
			end
			1: begin
				body.push_back(gle_pkg::ChLf);
				body.push_back(gle_pkg::ChCr);
			end
			2: begin
				body.push_back(gle_pkg::ChCr);
				body.push_back(gle_pkg::ChLf);
				body.push_back(gle_pkg::ChEtx);
			end
			default: ;
		endcase
		send_item(gle_pkg::OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 8'($urandom_range(255)));
		foreach (body[i]) begin
			if ($urandom_range(24) == 0)
				send_disruption();
			eoi = (i == body.size() - 1) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
			send_byte(body[i], eoi, $urandom_range(3), $urandom_range(1, 3));
		end
	endtask

	// Commands and ticks while no receive is open.
	task automatic test_idle_ops();
		send_item(gle_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 8'hFF);
		send_item(gle_pkg::OP_BREAK, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_UNUSED, 1'b1, 1'b1, 1'b1, 8'hFF);
	endtask

	// Receives ended by EOI, without and with the EOT request.
	task automatic test_eoi_end();
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_byte(8'hFF, 1'b1, 0, 1);
		wait_for_results();
		write_reg(gle_pkg::RegEotEn, 16'd1);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_byte(8'h00, 1'b0, 0, 1);
		send_byte(8'h5A, 1'b1, 0, 1);
	endtask

	// ATN with a byte held, restart while listening, unused op, then break.
	task automatic test_bus_aborts();
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, 8'h41);
		send_item(gle_pkg::OP_TICK, 1'b1, 1'b0, 1'b1, 8'h41);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_UNUSED, 1'b1, 1'b1, 1'b1, 8'hFF);
		send_item(gle_pkg::OP_BREAK, 1'b0, 1'b0, 1'b0, 8'h00);
	endtask

	// DAV-low timeout with a zero limit, DAV-high timeout with EOI held.
	task automatic test_dav_timeouts();
		wait_for_results();
		write_reg(gle_pkg::RegTimeout, 16'd0);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		wait_for_results();
		write_reg(gle_pkg::RegTimeout, 16'd1);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_item(gle_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h80);
		send_item(gle_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 8'h80);
	endtask

	// CR+LF terminator; EOI on the LF must not be latched outside EOI mode.
	task automatic test_crlf_end();
		wait_for_results();
		write_reg(gle_pkg::RegTimeout, 16'd100);
		write_reg(gle_pkg::RegEoiOnly, 16'd0);
		write_reg(gle_pkg::RegTermMode, {13'd0, gle_pkg::TmCrLf});
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		send_byte(gle_pkg::ChCr, 1'b0, 0, 1);
		send_byte(gle_pkg::ChLf, 1'b1, 0, 1);
	endtask

	// A longer limit, waited out in full.
	task automatic test_long_timeout();
		wait_for_results();
		write_reg(gle_pkg::RegTimeout, 16'd100);
		send_item(gle_pkg::OP_START, 1'b0, 1'b0, 1'b0, 8'h00);
		while (rx_phase != gle_pkg::PH_IDLE)
			send_item(gle_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'($urandom_range(255)));
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		wait_for_results();
		random_settings();
		no_idle  = 1'b1;
		hold_req = 1'b1;
		repeat (4) send_message();
		no_idle = 1'b0;
		wait_for_results();
	endtask

	// A long stretch with neither side idling.
	task automatic test_steady_stream();
		int start_count;
		wait_for_results();
		random_settings();
		no_idle     = 1'b1;
		start_count = sent_items;
		while (sent_items - start_count < 200)
			send_message();
		no_idle = 1'b0;
	endtask

	// Random phases, each under fresh settings.
	task automatic test_random_traffic(int count);
		int start_count;
		int phase_count;
		start_count = sent_items;
		while (sent_items - start_count < count) begin
			wait_for_results();
			random_settings();
			phase_count = sent_items;
			while (sent_items - phase_count < 100 && sent_items - start_count < count) begin
				send_message();
				if ($urandom_range(4) == 0)
					send_noise();
			end
		end
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= 19;
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			fault_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// Compares each result transfer with the oldest expectation.
	always @(posedge clk) begin : check_results
		gle_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				fault_count++;
				$error("result transfer with no expectation waiting");
			end else begin
				want = expected_results.pop_front();
				check_field("listening", want.listening, m_tdata[0]);
				check_field("nrfd_release", want.nrfd_release, m_tdata[1]);
				check_field("ndac_release", want.ndac_release, m_tdata[2]);
				check_field("byte_valid", want.byte_valid, m_tdata[3]);
				check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
				check_field("end_status", want.end_status, m_tdata[14:12]);
				check_field("append_eot", want.append_eot, m_tdata[15]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_ops();
		test_eoi_end();
		test_bus_aborts();
		test_dav_timeouts();
		test_crlf_end();
		test_long_timeout();
		test_backpressure();
		test_steady_stream();
		test_random_traffic(1100);
		wait_for_results();
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("gpib_listener_receive_engine_tb: PASS");
		else
			$display("gpib_listener_receive_engine_tb: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("gpib_listener_receive_engine_tb: FAIL");
		$finish;
	end

endmodule
